>>> src/bfu_pkg.sv
package bfu_pkg;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned FWIDTH_W   = 6;
  localparam int unsigned VALUE_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_SKIP = 2'd0,
    CFG_FIELD_WIDTH  = 2'd1,
    CFG_GAP_BITS     = 2'd2,
    CFG_FIELD_COUNT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } item_t;

  // Returns k bits of b starting at bit position start (0 is the MSB),
  // right justified.
  function automatic logic [7:0] get_bits(input logic [7:0] b, input logic [3:0] start,
                                          input logic [3:0] k);
    logic [7:0] t;
    t = b << start;
    return t >> (4'd8 - k);
  endfunction

endpackage

>>> src/bfu_front.sv
module bfu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_frame_start,
  output logic            q_valid,
  output bfu_pkg::item_t  q_item,
  input  logic            q_pop
);

  bfu_pkg::item_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].data  <= in_byte;
      mem_r[wr_ptr_r].start <= in_frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> src/bfu_back.sv
module bfu_back #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             q_valid,
  input  bfu_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bfu_pkg::VALUE_W-1:0]      out_field_value,
  output logic                             out_last_in_item,
  output logic                             out_final_field
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = bfu_pkg::COUNT_W;

  logic [CW-1:0]                   initial_skip_r;
  logic [bfu_pkg::FWIDTH_W-1:0]    field_width_r;
  logic [CW-1:0]                   gap_bits_r;
  logic [CW-1:0]                   field_count_r;

  logic [MAX_WIDTH-1:0] accum_r, accum_nxt;
  logic [WW-1:0]        bc_r, bc_nxt;
  logic [CW-1:0]        skip_r, skip_nxt;
  logic [CW-1:0]        fd_r, fd_nxt;
  logic                 active_r, active_nxt;
  logic [2:0]           pos_r, pos_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [bfu_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_final_r, out_final_nxt;

  logic [7:0]           w8;
  logic                 chunk;
  logic                 act;
  logic [MAX_WIDTH-1:0] acc;
  logic [MAX_WIDTH-1:0] val;
  logic [WW-1:0]        bc;
  logic [CW-1:0]        sk;
  logic [CW-1:0]        fd;
  logic [CW-1:0]        fd1;
  logic [3:0]           n;
  logic [3:0]           avail;
  logic [3:0]           start4;
  logic [7:0]           need8;
  logic [3:0]           k;
  logic [3:0]           k2;
  logic [3:0]           pnew;
  logic [3:0]           r;
  logic                 emit;
  logic                 done;
  logic                 last;
  logic                 fin;

  always_comb begin
    w8 = {2'b00, field_width_r};
    if (w8 == 8'd0) begin
      w8 = 8'd1;
    end
    if (w8 > 8'(MAX_WIDTH)) begin
      w8 = 8'(MAX_WIDTH);
    end
  end

  always_comb begin
    chunk  = q_valid && (!out_valid_r || !out_stall);
    act    = active_r;
    acc    = accum_r;
    bc     = bc_r;
    sk     = skip_r;
    fd     = fd_r;
    fd1    = fd_r;
    val    = '0;
    avail  = 4'd0;
    start4 = 4'd0;
    need8  = 8'd0;
    k      = 4'd0;
    k2     = 4'd0;
    pnew   = 4'd0;
    r      = 4'd0;
    emit   = 1'b0;
    done   = 1'b1;
    last   = 1'b0;
    fin    = 1'b0;
    if (pos_r == 3'd0) begin
      if (q_item.start) begin
        act = 1'b1;
        acc = '0;
        bc  = '0;
        sk  = initial_skip_r;
        fd  = '0;
      end
      if (act && (fd >= field_count_r)) begin
        act = 1'b0;
      end
    end
    n = 4'd8 - {1'b0, pos_r};
    if (act) begin
      if (sk >= CW'(n)) begin
        sk = sk - CW'(n);
      end else begin
        avail  = n - sk[3:0];
        start4 = {1'b0, pos_r} + sk[3:0];
        // A width lowered below the bits already held completes on the next bit.
        need8  = (8'(bc) >= w8) ? 8'd1 : (w8 - 8'(bc));
        if (need8 > {4'd0, avail}) begin
          acc = (acc << avail) | MAX_WIDTH'(bfu_pkg::get_bits(q_item.data, start4, avail));
          bc  = bc + WW'(avail);
          sk  = '0;
        end else begin
          k    = need8[3:0];
          val  = (acc << k) | MAX_WIDTH'(bfu_pkg::get_bits(q_item.data, start4, k));
          fd1  = fd + CW'(1);
          fin  = (fd1 >= field_count_r);
          emit = 1'b1;
          acc  = '0;
          bc   = '0;
          sk   = gap_bits_r;
          fd   = fd1;
          pnew = start4 + k;
          if (fin) begin
            act  = 1'b0;
            last = 1'b1;
          end else begin
            r    = 4'd8 - pnew;
            last = (({1'b0, gap_bits_r} + (CW + 1)'(w8)) > (CW + 1)'(r));
            if (last) begin
              if (gap_bits_r >= CW'(r)) begin
                sk = gap_bits_r - CW'(r);
              end else begin
                k2  = r - gap_bits_r[3:0];
                acc = MAX_WIDTH'(bfu_pkg::get_bits(q_item.data, pnew + gap_bits_r[3:0], k2));
                bc  = WW'(k2);
                sk  = '0;
              end
            end else begin
              done = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    active_nxt    = active_r;
    accum_nxt     = accum_r;
    bc_nxt        = bc_r;
    skip_nxt      = skip_r;
    fd_nxt        = fd_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_final_nxt = out_final_r;
    if (chunk) begin
      active_nxt = act;
      accum_nxt  = acc;
      bc_nxt     = bc;
      skip_nxt   = sk;
      fd_nxt     = fd;
      pos_nxt    = done ? 3'd0 : pnew[2:0];
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = bfu_pkg::VALUE_W'(val);
        out_last_nxt  = last;
        out_final_nxt = fin;
      end
    end
  end

  assign q_pop            = chunk && done;
  assign out_valid        = out_valid_r;
  assign out_field_value  = out_value_r;
  assign out_last_in_item = out_last_r;
  assign out_final_field  = out_final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_skip_r <= '0;
      field_width_r  <= bfu_pkg::FWIDTH_W'(8);
      gap_bits_r     <= '0;
      field_count_r  <= CW'(1);
    end else if (cfg_we) begin
      unique case (bfu_pkg::cfg_idx_t'(cfg_index))
        bfu_pkg::CFG_INITIAL_SKIP: initial_skip_r <= cfg_wdata;
        bfu_pkg::CFG_FIELD_WIDTH:  field_width_r  <= cfg_wdata[bfu_pkg::FWIDTH_W-1:0];
        bfu_pkg::CFG_GAP_BITS:     gap_bits_r     <= cfg_wdata;
        bfu_pkg::CFG_FIELD_COUNT:  field_count_r  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      accum_r     <= '0;
      bc_r        <= '0;
      skip_r      <= '0;
      fd_r        <= '0;
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      accum_r     <= accum_nxt;
      bc_r        <= bc_nxt;
      skip_r      <= skip_nxt;
      fd_r        <= fd_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_final_r <= out_final_nxt;
  end

endmodule

>>> src/bit_field_unpacker_unit.sv
// MSB-first bit-field unpacker. Bytes enter a two-entry request queue and
// the extractor works through each byte in chunks, one chunk per cycle
// while out_stall is low; a chunk ends at a completed field or at the end
// of the byte. A byte completing no field or one field is one chunk, so one
// byte per cycle is sustained for fields wider than a byte; a byte completing
// k fields takes k chunks, fed through the single output register. Trailing
// bits after a byte's last field are absorbed in the same chunk as that
// field. The user must write configuration only while idle; not enforced.
module bit_field_unpacker_unit #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bfu_pkg::VALUE_W-1:0]      out_field_value,
  output logic                             out_last_in_item,
  output logic                             out_final_field
);

  logic           q_valid;
  bfu_pkg::item_t q_item;
  logic           q_pop;

  bfu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_frame_start (in_frame_start),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  bfu_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field_value  (out_field_value),
    .out_last_in_item (out_last_in_item),
    .out_final_field  (out_final_field)
  );

endmodule
